>>> rtl/bprt_pkg.sv
// Package for the batch packet receive tracker.
// Holds the frame constants, parameter defaults, register indexes and status codes.
// No dependencies.
package bprt_pkg;

  localparam int unsigned MAX_PACKETS_DEF = 256;
  localparam int unsigned MAX_BATCHES_DEF = 64;

  localparam logic [31:0] DATA_MAGIC  = 32'h5646_5542;
  localparam logic [10:0] FRAME_BYTES = 11'd1400;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_KEY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_GOAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_LEN_SRC   = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_DUP_CNT   = 3'd3,
    ST_FINISHED  = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        ack_send;
    logic [5:0]  ack_batch;
    logic [8:0]  ack_count;
    logic [6:0]  batches_done;
    logic        finished;
  } result_t;

endpackage

>>> rtl/batch_packet_receive_tracker.sv
// Top level of the batch packet receive tracker: header checks, sequence bitmap memory,
// batch bookkeeping and a two-entry result buffer.
// Depends on bprt_pkg.

// One datagram descriptor is taken per clock cycle while in_ready is high and yields
// exactly one result. A transfer lands in an input register while the sequence bitmap
// entry for it is read from a memory. The checks and the bitmap update run while the item
// sits in the input register, and its result is then registered into the output register
// or the skid entry. Each bitmap entry holds the batch number in which that sequence
// arrived, so a completed batch empties the bitmap just by advancing the batch count.
// After reset a clearing pass marks every entry empty, holding in_ready low until all
// MAX_PACKETS entries (256 by default) are clear. A skid entry behind the output register
// lets the input keep taking items while a result waits; in_ready drops only while
// clearing or when the input register and the skid entry are both full.
module batch_packet_receive_tracker #(
  parameter int unsigned MAX_PACKETS = bprt_pkg::MAX_PACKETS_DEF,
  parameter int unsigned MAX_BATCHES = bprt_pkg::MAX_BATCHES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bprt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [10:0]                     in_packet_length,
  input  logic [31:0]                     in_sender_address,
  input  logic [31:0]                     in_header_magic,
  input  logic [31:0]                     in_header_batch,
  input  logic [31:0]                     in_header_sequence,
  input  logic [31:0]                     in_header_count,
  input  logic [63:0]                     in_header_nonce,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic                            out_ack_send,
  output logic [5:0]                      out_ack_batch,
  output logic [8:0]                      out_ack_count,
  output logic [6:0]                      out_batches_done,
  output logic                            out_finished
);
  import bprt_pkg::*;

  localparam int unsigned IDX_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1);
  localparam int unsigned BAT_W = $clog2(MAX_BATCHES + 1);

  // Configuration registers.
  logic [63:0] nonce_key_r;
  logic [6:0]  batch_goal_r;
  logic [31:0] source_address_r;

  // Tracking state.
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [CNT_W-1:0]       latched_r, latched_nxt;
  logic [BAT_W-1:0]       completed_r, completed_nxt;
  logic                   done_r, done_nxt;

  // Sequence bitmap. An entry counts as seen when it holds the current batch number;
  // all ones marks an empty entry and never equals a batch still in progress.
  logic [BAT_W-1:0] seen_mem [MAX_PACKETS];
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [BAT_W-1:0] mem_wdata;

  // Input register.
  logic             p_v_r;
  logic [10:0]      p_len_r;
  logic [31:0]      p_sender_r, p_magic_r, p_batch_r, p_seq_r, p_count_r;
  logic [63:0]      p_nonce_r;
  logic [BAT_W-1:0] rd_tag_r;
  logic             fwd_hit_r;

  // Result buffer.
  result_t out_r, skid_r, res;
  logic    out_v_r, skid_v_r;

  logic             acc, fire, pop, mark, set_seen;
  logic             len_src_ok, hdr_ok, seen_bit, dup_or_mis, complete;
  logic [CNT_W-1:0] cnt_n, lat_eff;
  logic [IDX_W-1:0] seq_idx, in_idx;
  logic [31:0]      goal32, goal_eff, done32;

  assign in_ready = !clr_busy_r && !(p_v_r && skid_v_r);
  assign acc      = in_valid && in_ready;
  assign fire     = p_v_r && !skid_v_r;
  assign pop      = out_v_r && out_ready;
  assign in_idx   = in_header_sequence[IDX_W-1:0];
  assign set_seen = fire && mark;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonce_key_r      <= 64'd1;
      batch_goal_r     <= 7'd1;
      source_address_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NONCE_KEY:      nonce_key_r      <= cfg_data;
        REG_BATCH_GOAL:     batch_goal_r     <= cfg_data[6:0];
        REG_SOURCE_ADDRESS: source_address_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset, one bitmap entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(MAX_PACKETS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_busy_r || set_seen;
  assign mem_waddr = clr_busy_r ? clr_idx_r : seq_idx;
  assign mem_wdata = clr_busy_r ? '1 : completed_r;

  // The read happens at the transfer; a write to the same entry at that edge by the
  // item leaving the input register is caught by the forward flag.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wdata;
    end
    if (acc) begin
      rd_tag_r  <= seen_mem[in_idx];
      fwd_hit_r <= set_seen && (seq_idx == in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (acc) begin
      p_v_r <= 1'b1;
    end else if (fire) begin
      p_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_len_r    <= in_packet_length;
      p_sender_r <= in_sender_address;
      p_magic_r  <= in_header_magic;
      p_batch_r  <= in_header_batch;
      p_seq_r    <= in_header_sequence;
      p_count_r  <= in_header_count;
      p_nonce_r  <= in_header_nonce;
    end
  end

  // Goal clamped to 1..MAX_BATCHES.
  always_comb begin
    goal32 = {25'd0, batch_goal_r};
    if (goal32 == 32'd0) begin
      goal_eff = 32'd1;
    end else if (goal32 > 32'(MAX_BATCHES)) begin
      goal_eff = 32'(MAX_BATCHES);
    end else begin
      goal_eff = goal32;
    end
  end

  always_comb begin
    len_src_ok = (p_len_r == FRAME_BYTES) &&
                 (p_sender_r == source_address_r);
    hdr_ok = (p_magic_r == DATA_MAGIC) && (p_nonce_r == nonce_key_r) &&
             (p_batch_r == 32'(completed_r)) && (p_count_r != 32'd0) &&
             (p_count_r <= 32'(MAX_PACKETS)) &&
             (p_seq_r < p_count_r);
    // Both are only meaningful when the header checks pass, which bounds them.
    cnt_n    = p_count_r[CNT_W-1:0];
    seq_idx  = p_seq_r[IDX_W-1:0];
    seen_bit = fwd_hit_r || (rd_tag_r == completed_r);
    lat_eff  = (latched_r == '0) ? cnt_n : latched_r;
    dup_or_mis = (lat_eff != cnt_n) || seen_bit;
    complete   = ((total_r + 1'b1) == lat_eff);

    total_nxt     = total_r;
    latched_nxt   = latched_r;
    completed_nxt = completed_r;
    done_nxt      = done_r;
    done32        = 32'(completed_r + 1'b1);
    mark          = 1'b0;

    res.status    = ST_ACCEPTED;
    res.ack_send  = 1'b0;
    res.ack_batch = '0;
    res.ack_count = '0;

    if (done_r) begin
      res.status = ST_FINISHED;
    end else if (!len_src_ok) begin
      res.status = ST_LEN_SRC;
    end else if (!hdr_ok) begin
      res.status = ST_BAD_HDR;
    end else begin
      // The first good count of a batch is latched even if the item is then dropped.
      latched_nxt = lat_eff;
      if (dup_or_mis) begin
        res.status = ST_DUP_CNT;
      end else if (complete) begin
        res.ack_send  = 1'b1;
        res.ack_batch = p_batch_r[5:0];
        res.ack_count = 9'(lat_eff);
        completed_nxt = completed_r + 1'b1;
        total_nxt     = '0;
        latched_nxt   = '0;
        done_nxt      = (done32 >= goal_eff);
      end else begin
        mark      = 1'b1;
        total_nxt = total_r + 1'b1;
      end
    end

    res.batches_done = 7'(completed_nxt);
    res.finished     = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      latched_r   <= '0;
      completed_r <= '0;
      done_r      <= 1'b0;
    end else if (fire) begin
      total_r     <= total_nxt;
      latched_r   <= latched_nxt;
      completed_r <= completed_nxt;
      done_r      <= done_nxt;
    end
  end

  // Output register plus skid entry; the skid fills only when a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (fire) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (fire) begin
      if (!out_v_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_r.status;
  assign out_ack_send     = out_r.ack_send;
  assign out_ack_batch    = out_r.ack_batch;
  assign out_ack_count    = out_r.ack_count;
  assign out_batches_done = out_r.batches_done;
  assign out_finished     = out_r.finished;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a result while the output register is empty");

  a_ack_is_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ack_send) |-> (out_status == ST_ACCEPTED))
    else $error("acknowledgement requested on a dropped item");

  a_done_has_batches: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (completed_r != '0))
    else $error("finished without any completed batch");

  a_total_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r == '0) |-> (total_r == '0))
    else $error("packets counted with no latched batch count");

  a_total_below_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r != '0) |-> (total_r < latched_r))
    else $error("received total reached the latched count without completing");

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("input ready while the bitmap is still being cleared");

endmodule
